// ===== rtl/core/rcu8_pkg.sv =====
`timescale 1ns / 1ps

package rcu8_pkg;

    localparam int WORD_W          = 32;
    localparam int CP_W            = 21;
    localparam int CHARS_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int STEP_W          = $clog2(WORD_W);
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS = 2'd2;

    localparam logic [CP_W-1:0]    LOWER_RST = 21'd65;
    localparam logic [CP_W-1:0]    UPPER_RST = 21'd90;
    localparam logic [CHARS_W-1:0] CHARS_RST = 16'd16;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] C0_LO       = 21'h000000;
    localparam logic [CP_W-1:0] C0_HI       = 21'h00001F;
    localparam logic [CP_W-1:0] C1_LO       = 21'h00007F;
    localparam logic [CP_W-1:0] C1_HI       = 21'h00009F;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] BIDI_LO     = 21'h00202A;
    localparam logic [CP_W-1:0] BIDI_HI     = 21'h00202E;
    localparam logic [CP_W-1:0] ISO_LO      = 21'h002066;
    localparam logic [CP_W-1:0] ISO_HI      = 21'h002069;
    localparam logic [CP_W-1:0] ZW_LO       = 21'h00200B;
    localparam logic [CP_W-1:0] ZW_HI       = 21'h00200D;
    localparam logic [CP_W-1:0] WJ_CP       = 21'h002060;
    localparam logic [CP_W-1:0] BOM_CP      = 21'h00FEFF;
    localparam logic [CP_W-1:0] NONCH_LO    = 21'h00FDD0;
    localparam logic [CP_W-1:0] NONCH_HI    = 21'h00FDEF;
    localparam logic [CP_W-1:0] TAG_LO      = 21'h0E0000;
    localparam logic [CP_W-1:0] TAG_HI      = 21'h0E007F;
    localparam logic [15:0]     PLANE_NONCH = 16'hFFFE;

    localparam logic [CP_W-1:0] LIM_1B = 21'h000080;
    localparam logic [CP_W-1:0] LIM_2B = 21'h000800;
    localparam logic [CP_W-1:0] LIM_3B = 21'h010000;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fix;
        logic chk;
        logic next_byte;
        logic show_err;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic reject;
        logic last_byte;
    } t_sts;

endpackage

// ===== rtl/core/random_codepoint_utf8_generator.sv =====
`timescale 1ns / 1ps
// The first byte of a character is valid once its item has passed the divide, fix and check states.
// An item holds the block until its last byte is taken, or until the check if rejected; no new item is taken before.
// The divide state runs a 32-step restoring divider that reduces the word modulo the range.
// With an invalid range, each item gives its error result in the next cycle.
// Synchronous active-low reset restores the register defaults and clears the char count.
module random_codepoint_utf8_generator #(
    parameter int COUNT_WIDTH = rcu8_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rcu8_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcu8_pkg::CP_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rcu8_pkg::WORD_W-1:0]       i_raw_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rcu8_pkg::BYTE_W-1:0]       o_utf8_byte,
    output logic                              o_char_end,
    output logic                              o_string_end,
    output logic                              o_status
);

    rcu8_pkg::t_cmd cmd;
    rcu8_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rcu8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcu8_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_raw_word   (i_raw_word),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_utf8_byte  (o_utf8_byte),
        .o_char_end   (o_char_end),
        .o_string_end (o_string_end),
        .o_status     (o_status)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_utf8_byte == '0) && !o_char_end && !o_string_end)
        else $error("error result carries payload");

    a_str_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_end) |-> o_char_end)
        else $error("string end off a character end");

    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_status && !o_char_end) |=> o_out_valid)
        else $error("character cut short");

endmodule

// ===== rtl/core/rcu8_ctrl.sv =====
`timescale 1ns / 1ps

module rcu8_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rcu8_pkg::t_sts    i_sts,
    output rcu8_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_FIX  = 6'b000100,
        S_CHK  = 6'b001000,
        S_OUT  = 6'b010000,
        S_ERR  = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [rcu8_pkg::STEP_W-1:0]  r_step, n_step;
    logic                         div_done;

    assign div_done    = (r_step == rcu8_pkg::STEP_W'(rcu8_pkg::WORD_W - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT) || (r_state == S_ERR);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    if (i_sts.invalid) begin
                        n_state = S_ERR;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.reject ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_byte = 1'b1;
                    end
                end
            end
            S_ERR: begin
                o_cmd.show_err = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/core/rcu8_dpath.sv =====
`timescale 1ns / 1ps

module rcu8_dpath #(
    parameter int COUNT_WIDTH = rcu8_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcu8_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcu8_pkg::CP_W-1:0]         i_cfg_data,
    input  logic [rcu8_pkg::WORD_W-1:0]       i_raw_word,
    input  rcu8_pkg::t_cmd                    i_cmd,
    output rcu8_pkg::t_sts                    o_sts,
    output logic [rcu8_pkg::BYTE_W-1:0]       o_utf8_byte,
    output logic                              o_char_end,
    output logic                              o_string_end,
    output logic                              o_status
);

    localparam int CMP_W = (COUNT_WIDTH + 1 > rcu8_pkg::CHARS_W + 1) ?
                           COUNT_WIDTH + 1 : rcu8_pkg::CHARS_W + 1;

    logic [rcu8_pkg::CP_W-1:0]    r_lower, r_upper;
    logic [rcu8_pkg::CHARS_W-1:0] r_chars;
    logic [rcu8_pkg::WORD_W-1:0]  r_word, r_word_orig;
    logic [rcu8_pkg::CP_W-1:0]    r_range, r_rem, r_cp, r_gap;
    logic [rcu8_pkg::BYTE_W-1:0]  r_bytes [4];
    logic [1:0]                   r_last_idx, r_idx;
    logic                         r_str_last;
    logic [COUNT_WIDTH-1:0]       r_cd;

    logic                         invalid;
    logic [rcu8_pkg::CP_W:0]      trial;
    logic [rcu8_pkg::CP_W-1:0]    rem_next;
    logic [rcu8_pkg::WORD_W:0]    span;
    logic                         reject;
    logic [COUNT_WIDTH:0]         cd_inc;
    logic                         str_last;

    function automatic logic touches(input logic [rcu8_pkg::CP_W-1:0] lo,
                                     input logic [rcu8_pkg::CP_W-1:0] hi,
                                     input logic [rcu8_pkg::CP_W-1:0] a,
                                     input logic [rcu8_pkg::CP_W-1:0] b);
        return (lo <= b) && (hi >= a);
    endfunction

    // The first plane noncharacter pair at or above the lower bound sits in the
    // lower bound's own plane, so one compare covers all seventeen planes.
    assign invalid = (r_lower >= r_upper) || (r_upper > rcu8_pkg::CP_MAX) ||
        touches(r_lower, r_upper, rcu8_pkg::C0_LO,    rcu8_pkg::C0_HI)    ||
        touches(r_lower, r_upper, rcu8_pkg::C1_LO,    rcu8_pkg::C1_HI)    ||
        touches(r_lower, r_upper, rcu8_pkg::SURR_LO,  rcu8_pkg::SURR_HI)  ||
        touches(r_lower, r_upper, rcu8_pkg::BIDI_LO,  rcu8_pkg::BIDI_HI)  ||
        touches(r_lower, r_upper, rcu8_pkg::ISO_LO,   rcu8_pkg::ISO_HI)   ||
        touches(r_lower, r_upper, rcu8_pkg::ZW_LO,    rcu8_pkg::ZW_HI)    ||
        touches(r_lower, r_upper, rcu8_pkg::WJ_CP,    rcu8_pkg::WJ_CP)    ||
        touches(r_lower, r_upper, rcu8_pkg::BOM_CP,   rcu8_pkg::BOM_CP)   ||
        touches(r_lower, r_upper, rcu8_pkg::NONCH_LO, rcu8_pkg::NONCH_HI) ||
        touches(r_lower, r_upper, rcu8_pkg::TAG_LO,   rcu8_pkg::TAG_HI)   ||
        (r_upper >= {r_lower[rcu8_pkg::CP_W-1:16], rcu8_pkg::PLANE_NONCH});

    assign trial    = {r_rem, r_word[rcu8_pkg::WORD_W-1]};
    assign rem_next = (trial >= {1'b0, r_range}) ?
                      rcu8_pkg::CP_W'(trial - {1'b0, r_range}) :
                      trial[rcu8_pkg::CP_W-1:0];

    // The word lies in the last, partial block of the range exactly when the
    // next multiple of the range above it would pass 2^32.
    assign span   = {1'b0, r_word_orig} +
                    (rcu8_pkg::WORD_W + 1)'(r_gap);
    assign reject = span[rcu8_pkg::WORD_W] && (span[rcu8_pkg::WORD_W-1:0] != '0);

    assign cd_inc   = {1'b0, r_cd} + 1'b1;
    assign str_last = (&r_cd) || (CMP_W'(cd_inc) >= CMP_W'(r_chars));

    assign o_sts.invalid   = invalid;
    assign o_sts.reject    = reject;
    assign o_sts.last_byte = (r_idx == r_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= rcu8_pkg::LOWER_RST;
            r_upper <= rcu8_pkg::UPPER_RST;
            r_chars <= rcu8_pkg::CHARS_RST;
            r_cd    <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcu8_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                    rcu8_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                    rcu8_pkg::CFG_CHARS: r_chars <= i_cfg_data[rcu8_pkg::CHARS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.chk) begin
                r_idx <= '0;
                if (!reject) begin
                    r_cd <= str_last ? '0 : cd_inc[COUNT_WIDTH-1:0];
                end
            end else if (i_cmd.next_byte) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word      <= i_raw_word;
            r_word_orig <= i_raw_word;
            r_rem       <= '0;
            r_range     <= r_upper - r_lower + 1'b1;
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_next;
            r_word <= {r_word[rcu8_pkg::WORD_W-2:0], 1'b0};
        end
        if (i_cmd.fix) begin
            r_cp  <= r_rem + r_lower;
            r_gap <= r_range - r_rem;
        end
        if (i_cmd.chk) begin
            r_str_last <= str_last;
            r_bytes[3] <= {2'b10, r_cp[5:0]};
            if (r_cp < rcu8_pkg::LIM_1B) begin
                r_bytes[0] <= {1'b0, r_cp[6:0]};
                r_bytes[1] <= {2'b10, r_cp[11:6]};
                r_bytes[2] <= {2'b10, r_cp[5:0]};
                r_last_idx <= 2'd0;
            end else if (r_cp < rcu8_pkg::LIM_2B) begin
                r_bytes[0] <= {3'b110, r_cp[10:6]};
                r_bytes[1] <= {2'b10, r_cp[5:0]};
                r_bytes[2] <= {2'b10, r_cp[5:0]};
                r_last_idx <= 2'd1;
            end else if (r_cp < rcu8_pkg::LIM_3B) begin
                r_bytes[0] <= {4'b1110, r_cp[15:12]};
                r_bytes[1] <= {2'b10, r_cp[11:6]};
                r_bytes[2] <= {2'b10, r_cp[5:0]};
                r_last_idx <= 2'd2;
            end else begin
                r_bytes[0] <= {5'b11110, r_cp[20:18]};
                r_bytes[1] <= {2'b10, r_cp[17:12]};
                r_bytes[2] <= {2'b10, r_cp[11:6]};
                r_last_idx <= 2'd3;
            end
        end
    end

    always_comb begin
        if (i_cmd.show_err) begin
            o_utf8_byte  = '0;
            o_char_end   = 1'b0;
            o_string_end = 1'b0;
            o_status     = 1'b1;
        end else begin
            o_utf8_byte  = r_bytes[r_idx];
            o_char_end   = o_sts.last_byte;
            o_string_end = o_sts.last_byte && r_str_last;
            o_status     = 1'b0;
        end
    end

endmodule

// ===== sim/random_codepoint_utf8_generator_test.sv =====
`timescale 1ns / 1ps

module random_codepoint_utf8_generator_test;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 300;
    localparam int SETTLE_CYCLES = 45;
    localparam int BAD_RANGES    = 13;
    localparam int GOOD_RANGES   = 9;

    localparam logic [rcu8_pkg::CP_W-1:0] BAD_LO [BAD_RANGES] = '{
        21'h000041, 21'h1FFFFF, 21'h010000, 21'h000000, 21'h000070, 21'h00D000, 21'h002020,
        21'h002069, 21'h00200D, 21'h002050, 21'h00FEFF, 21'h00FDEF, 21'h10FFF0
    };
    localparam logic [rcu8_pkg::CP_W-1:0] BAD_HI [BAD_RANGES] = '{
        21'h000041, 21'h000100, 21'h1FFFFF, 21'h000041, 21'h000080, 21'h00D800, 21'h00202A,
        21'h00206F, 21'h002010, 21'h002060, 21'h00FF00, 21'h00FDF5, 21'h10FFFF
    };
    localparam logic [rcu8_pkg::CP_W-1:0] GOOD_LO [GOOD_RANGES] = '{
        21'h000020, 21'h000041, 21'h0000A0, 21'h0000A0, 21'h003000, 21'h00E000, 21'h010000,
        21'h020000, 21'h100000
    };
    localparam logic [rcu8_pkg::CP_W-1:0] GOOD_HI [GOOD_RANGES] = '{
        21'h00007E, 21'h00005A, 21'h0007FF, 21'h002009, 21'h00D7FF, 21'h00F8FF, 21'h01FFFD,
        21'h02FFFD, 21'h10FFFD
    };

    typedef struct packed {
        logic [rcu8_pkg::BYTE_W-1:0] code_byte;
        logic                        char_end;
        logic                        string_end;
        logic                        status;
    } t_utf8_out;

    class t_byte_ledger;
        logic [rcu8_pkg::CP_W-1:0]    lower_cp;
        logic [rcu8_pkg::CP_W-1:0]    upper_cp;
        logic [rcu8_pkg::CHARS_W-1:0] chars_per_string;
        logic [rcu8_pkg::CHARS_W-1:0] chars_done;
        t_utf8_out                    due_bytes[$];
        int                           mismatches;
        int                           bytes_checked;
        int                           error_results;
        int                           rejected_words;
        int                           strings_ended;

        function new();
            mismatches     = 0;
            bytes_checked  = 0;
            error_results  = 0;
            rejected_words = 0;
            strings_ended  = 0;
            clear();
        endfunction

        function void clear();
            lower_cp         = rcu8_pkg::LOWER_RST;
            upper_cp         = rcu8_pkg::UPPER_RST;
            chars_per_string = rcu8_pkg::CHARS_RST;
            chars_done       = '0;
            due_bytes.delete();
        endfunction

        function void write_reg(logic [rcu8_pkg::CFG_IDX_W-1:0] idx,
                                logic [rcu8_pkg::CP_W-1:0] data);
            case (idx)
                rcu8_pkg::CFG_LOWER: lower_cp = data;
                rcu8_pkg::CFG_UPPER: upper_cp = data;
                rcu8_pkg::CFG_CHARS: chars_per_string = data[rcu8_pkg::CHARS_W-1:0];
                default: ;
            endcase
        endfunction

        function bit touches(logic [rcu8_pkg::CP_W-1:0] lo_cp,
                             logic [rcu8_pkg::CP_W-1:0] hi_cp);
            return (lower_cp <= hi_cp) && (upper_cp >= lo_cp);
        endfunction

        function bit range_bad();
            int unsigned base;
            if (lower_cp >= upper_cp || upper_cp > rcu8_pkg::CP_MAX) return 1'b1;
            if (touches(rcu8_pkg::C0_LO, rcu8_pkg::C0_HI) ||
                touches(rcu8_pkg::C1_LO, rcu8_pkg::C1_HI) ||
                touches(rcu8_pkg::SURR_LO, rcu8_pkg::SURR_HI) ||
                touches(rcu8_pkg::BIDI_LO, rcu8_pkg::BIDI_HI) ||
                touches(rcu8_pkg::ISO_LO, rcu8_pkg::ISO_HI) ||
                touches(rcu8_pkg::ZW_LO, rcu8_pkg::ZW_HI) ||
                touches(rcu8_pkg::WJ_CP, rcu8_pkg::WJ_CP) ||
                touches(rcu8_pkg::BOM_CP, rcu8_pkg::BOM_CP) ||
                touches(rcu8_pkg::NONCH_LO, rcu8_pkg::NONCH_HI) ||
                touches(rcu8_pkg::TAG_LO, rcu8_pkg::TAG_HI))
                return 1'b1;
            for (int p = 0; p <= 16; p++) begin
                base = p * 32'h1_0000;
                if (touches(rcu8_pkg::CP_W'(base + 32'(rcu8_pkg::PLANE_NONCH)),
                            rcu8_pkg::CP_W'(base + 32'hFFFF)))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // Words at or above this bound are discarded so that the modulo stays uniform.
        function longint unsigned reject_floor();
            longint unsigned span;
            span = 64'(upper_cp) - 64'(lower_cp) + 64'd1;
            return 64'h1_0000_0000 - (64'h1_0000_0000 % span);
        endfunction

        function int note_word(logic [rcu8_pkg::WORD_W-1:0] word);
            longint unsigned             span;
            logic [rcu8_pkg::CP_W-1:0]   cp;
            logic [rcu8_pkg::BYTE_W-1:0] enc [4];
            t_utf8_out                   due;
            int                          n;
            bit                          ends_string;
            if (range_bad()) begin
                due = '{code_byte: '0, char_end: 1'b0, string_end: 1'b0, status: 1'b1};
                due_bytes.push_back(due);
                error_results++;
                return 1;
            end
            span = 64'(upper_cp) - 64'(lower_cp) + 64'd1;
            if (64'(word) >= reject_floor()) begin
                rejected_words++;
                return 0;
            end
            cp = rcu8_pkg::CP_W'(64'(word) % span) + lower_cp;
            if (cp < rcu8_pkg::LIM_1B) begin
                enc[0] = cp[7:0];
                n = 1;
            end else if (cp < rcu8_pkg::LIM_2B) begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
                n = 2;
            end else if (cp < rcu8_pkg::LIM_3B) begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
                n = 3;
            end else begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
                n = 4;
            end
            ends_string = (chars_done == '1) ||
                          (32'(chars_done) + 1 >= 32'(chars_per_string));
            chars_done = ends_string ? '0 : chars_done + 1'b1;
            if (ends_string) strings_ended++;
            for (int k = 0; k < n; k++) begin
                due.code_byte  = enc[k];
                due.char_end   = (k == n - 1);
                due.string_end = (k == n - 1) && ends_string;
                due.status     = 1'b0;
                due_bytes.push_back(due);
            end
            return n;
        endfunction

        function void check_byte(logic [rcu8_pkg::BYTE_W-1:0] code_byte, logic char_end,
                                 logic string_end, logic status);
            t_utf8_out want;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected byte %02h char_end %0b string_end %0b status %0b",
                             code_byte, char_end, string_end, status);
                return;
            end
            want = due_bytes.pop_front();
            bytes_checked++;
            if (code_byte !== want.code_byte || char_end !== want.char_end ||
                string_end !== want.string_end || status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Byte %0d: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                             bytes_checked, want.code_byte, want.char_end, want.string_end,
                             want.status, code_byte, char_end, string_end, status);
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rcu8_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [rcu8_pkg::CP_W-1:0]      i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [rcu8_pkg::WORD_W-1:0]    i_raw_word;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [rcu8_pkg::BYTE_W-1:0]    o_utf8_byte;
    logic                           o_char_end;
    logic                           o_string_end;
    logic                           o_status;

    t_byte_ledger ledger;
    int           tx_idle_pct  = 38;
    int           rx_idle_pct  = 75;
    bit           hold_request = 1'b0;
    bit           hold_taken   = 1'b0;
    int           hold_left    = 0;
    int           quiet_cycles = 0;

    random_codepoint_utf8_generator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_word   (i_raw_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_utf8_byte  (o_utf8_byte),
        .o_char_end   (o_char_end),
        .o_string_end (o_string_end),
        .o_status     (o_status)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("No handshake for %0d cycles, giving up.", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // The byte sink; a hold request stalls it once.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                ledger.check_byte(o_utf8_byte, o_char_end, o_string_end, o_status);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [rcu8_pkg::WORD_W-1:0] word, output int made);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_raw_word <= word;
        do @(posedge i_clk); while (!o_in_ready);
        made = ledger.note_word(word);
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (ledger.due_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [rcu8_pkg::CP_W-1:0] lo,
                              input logic [rcu8_pkg::CP_W-1:0] hi,
                              input logic [rcu8_pkg::CHARS_W-1:0] chars);
        logic [rcu8_pkg::CFG_IDX_W-1:0] idxs [3];
        logic [rcu8_pkg::CP_W-1:0]      vals [3];
        idxs = '{rcu8_pkg::CFG_LOWER, rcu8_pkg::CFG_UPPER, rcu8_pkg::CFG_CHARS};
        vals = '{lo, hi, rcu8_pkg::CP_W'(chars)};
        quiesce();
        i_cfg_valid <= 1'b1;
        for (int r = 0; r < 3; r++) begin
            i_cfg_index <= idxs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            ledger.write_reg(idxs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        longint unsigned              floor;
        logic [rcu8_pkg::WORD_W-1:0]  word;
        logic [rcu8_pkg::CP_W-1:0]    lo;
        logic [rcu8_pkg::CP_W-1:0]    hi;
        logic [rcu8_pkg::CHARS_W-1:0] chars;
        int                           made;
        int                           productive;
        int                           words_sent;
        int                           slot;
        int                           burst;
        bit                           held;
        bit                           paused;

        ledger      = new();
        productive  = 0;
        words_sent  = 0;
        held        = 1'b0;
        paused      = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= rcu8_pkg::CFG_LOWER;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_raw_word  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset range: words on both sides of the rejection bound.
        floor = ledger.reject_floor();
        send_word(rcu8_pkg::WORD_W'(floor - 1), made);
        send_word(rcu8_pkg::WORD_W'(floor), made);
        send_word('1, made);
        send_word('0, made);

        set_config(21'h20, 21'h7E, 16'd1);
        send_word(32'h0000_005E, made);
        send_word(32'hAAAA_AAAA, made);
        set_config(21'hA0, 21'h7FF, 16'd0);
        send_word(32'h5555_5555, made);
        send_word(32'h1234_5678, made);
        set_config(21'h100, 21'h1FF, 16'd2);
        send_word('1, made);
        set_config(21'h3000, 21'hD7FF, 16'hFFFF);
        send_word(32'h8000_0000, made);
        set_config(21'h100000, 21'h10FFFD, 16'hFFFF);
        send_word(32'h0000_FFFD, made);
        send_word(32'h7FFF_FFFF, made);
        // Shrinking the string length mid-string makes the next character close the current string.
        set_config(21'h100000, 21'h10FFFD, 16'd2);
        send_word(32'hDEAD_BEEF, made);

        for (int b = 0; b < BAD_RANGES; b++) begin
            set_config(BAD_LO[b], BAD_HI[b], 16'd4);
            send_word($urandom, made);
        end
        words_sent = 26;

        while (productive < RANDOM_WORDS) begin
            if (productive < RANDOM_WORDS / 3) begin
                tx_idle_pct = 38;
                rx_idle_pct = 75;
            end else if (productive < 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 75;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if ($urandom_range(5) == 0) begin
                lo = rcu8_pkg::CP_W'($urandom);
                hi = rcu8_pkg::CP_W'($urandom);
            end else begin
                slot = $urandom_range(GOOD_RANGES - 1);
                if ($urandom_range(1) == 0) begin
                    lo = GOOD_LO[slot];
                    hi = GOOD_HI[slot];
                end else begin
                    lo = rcu8_pkg::CP_W'($urandom_range(GOOD_HI[slot] - 1, GOOD_LO[slot]));
                    hi = rcu8_pkg::CP_W'($urandom_range(GOOD_HI[slot], lo + 1'b1));
                end
            end
            case ($urandom_range(3))
                0: chars = rcu8_pkg::CHARS_W'($urandom_range(4));
                1: chars = rcu8_pkg::CHARS_W'($urandom_range(40, 5));
                2: chars = 16'hFFFF;
                default: chars = rcu8_pkg::CHARS_W'($urandom_range(16'hFFFF));
            endcase
            set_config(lo, hi, chars);
            floor = ledger.range_bad() ? 64'h1_0000_0000 : ledger.reject_floor();

            burst = $urandom_range(30, 8);
            for (int k = 0; k < burst; k++) begin
                if (floor < 64'h1_0000_0000 && $urandom_range(9) == 0)
                    word = $urandom_range(32'hFFFF_FFFF, rcu8_pkg::WORD_W'(floor));
                else
                    word = $urandom;
                send_word(word, made);
                words_sent++;
                if (made > 0) productive++;
                if (!held && productive >= RANDOM_WORDS / 2) begin
                    held = 1'b1;
                    hold_request = 1'b1;
                end
                if (!paused && productive >= 3 * RANDOM_WORDS / 4) begin
                    paused = 1'b1;
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (ledger.due_bytes.size() != 0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (ledger.due_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d words over all three handshake timing modes, %0d bytes checked.",
                 words_sent, ledger.bytes_checked);
        $display("Range errors %0d, rejected words %0d, strings ended %0d, mismatches %0d.",
                 ledger.error_results, ledger.rejected_words, ledger.strings_ended,
                 ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.due_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== random_codepoint_utf8_generator.f =====
rtl/core/rcu8_pkg.sv
rtl/core/rcu8_ctrl.sv
rtl/core/rcu8_dpath.sv
rtl/core/random_codepoint_utf8_generator.sv
sim/random_codepoint_utf8_generator_test.sv
